### design/stpwm_pkg.sv
// Shared types, constants and the half-sine table for the sine PWM generator.
package stpwm_pkg;

    localparam int unsigned ROM_DEPTH = 300;
    localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
    localparam int unsigned CMP_W     = 11;
    localparam int unsigned AMP_W     = 24;
    localparam int unsigned FRAC_BITS = 23;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned THR_W     = 13;
    localparam int unsigned SAMP_W    = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [AMP_W-1:0] AMP_ONE   = AMP_W'(8388608);
    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(6710886);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 2'd0,
        CFG_LOW    = 2'd1,
        CFG_HIGH   = 2'd2,
        CFG_OFFSET = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FILL_RUN  = 1'b0,
        FILL_DONE = 1'b1
    } t_fill_state;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [THR_W-1:0]  low_thr;
        logic [THR_W-1:0]  high_thr;
        logic [SAMP_W-1:0] offset;
    } t_cfg;

    // Per-word bookkeeping that rides along with the table read.
    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic             half;
        logic             in_rom;
    } t_issue;

    localparam logic [CMP_W-1:0] SINE_ROM [ROM_DEPTH] = '{
        11'd60,   11'd77,   11'd94,   11'd110,  11'd127,  11'd144,
        11'd161,  11'd178,  11'd194,  11'd211,  11'd228,  11'd244,
        11'd261,  11'd278,  11'd294,  11'd311,  11'd328,  11'd344,
        11'd361,  11'd377,  11'd394,  11'd410,  11'd427,  11'd443,
        11'd459,  11'd475,  11'd492,  11'd508,  11'd524,  11'd540,
        11'd556,  11'd572,  11'd588,  11'd604,  11'd619,  11'd635,
        11'd651,  11'd666,  11'd682,  11'd697,  11'd713,  11'd728,
        11'd743,  11'd759,  11'd774,  11'd789,  11'd804,  11'd818,
        11'd833,  11'd848,  11'd863,  11'd877,  11'd891,  11'd906,
        11'd920,  11'd934,  11'd948,  11'd962,  11'd976,  11'd990,
        11'd1003, 11'd1017, 11'd1030, 11'd1044, 11'd1057, 11'd1070,
        11'd1083, 11'd1096, 11'd1109, 11'd1121, 11'd1134, 11'd1146,
        11'd1159, 11'd1171, 11'd1183, 11'd1195, 11'd1207, 11'd1218,
        11'd1230, 11'd1241, 11'd1253, 11'd1264, 11'd1275, 11'd1286,
        11'd1297, 11'd1307, 11'd1318, 11'd1328, 11'd1338, 11'd1349,
        11'd1358, 11'd1368, 11'd1378, 11'd1387, 11'd1397, 11'd1406,
        11'd1415, 11'd1424, 11'd1433, 11'd1441, 11'd1450, 11'd1458,
        11'd1466, 11'd1474, 11'd1482, 11'd1490, 11'd1498, 11'd1505,
        11'd1512, 11'd1519, 11'd1526, 11'd1533, 11'd1540, 11'd1546,
        11'd1552, 11'd1558, 11'd1564, 11'd1570, 11'd1576, 11'd1581,
        11'd1586, 11'd1592, 11'd1596, 11'd1601, 11'd1606, 11'd1610,
        11'd1615, 11'd1619, 11'd1623, 11'd1626, 11'd1630, 11'd1633,
        11'd1637, 11'd1640, 11'd1643, 11'd1645, 11'd1648, 11'd1650,
        11'd1652, 11'd1654, 11'd1656, 11'd1658, 11'd1659, 11'd1661,
        11'd1662, 11'd1663, 11'd1664, 11'd1664, 11'd1665, 11'd1665,
        11'd1665, 11'd1665, 11'd1665, 11'd1664, 11'd1664, 11'd1663,
        11'd1662, 11'd1661, 11'd1659, 11'd1658, 11'd1656, 11'd1654,
        11'd1652, 11'd1650, 11'd1648, 11'd1645, 11'd1643, 11'd1640,
        11'd1637, 11'd1633, 11'd1630, 11'd1626, 11'd1623, 11'd1619,
        11'd1615, 11'd1610, 11'd1606, 11'd1601, 11'd1596, 11'd1592,
        11'd1586, 11'd1581, 11'd1576, 11'd1570, 11'd1564, 11'd1558,
        11'd1552, 11'd1546, 11'd1540, 11'd1533, 11'd1526, 11'd1519,
        11'd1512, 11'd1505, 11'd1498, 11'd1490, 11'd1482, 11'd1474,
        11'd1466, 11'd1458, 11'd1450, 11'd1441, 11'd1433, 11'd1424,
        11'd1415, 11'd1406, 11'd1397, 11'd1387, 11'd1378, 11'd1368,
        11'd1358, 11'd1349, 11'd1338, 11'd1328, 11'd1318, 11'd1307,
        11'd1297, 11'd1286, 11'd1275, 11'd1264, 11'd1253, 11'd1241,
        11'd1230, 11'd1218, 11'd1207, 11'd1195, 11'd1183, 11'd1171,
        11'd1159, 11'd1146, 11'd1134, 11'd1121, 11'd1109, 11'd1096,
        11'd1083, 11'd1070, 11'd1057, 11'd1044, 11'd1030, 11'd1017,
        11'd1003, 11'd990,  11'd976,  11'd962,  11'd948,  11'd934,
        11'd920,  11'd906,  11'd891,  11'd877,  11'd862,  11'd848,
        11'd833,  11'd818,  11'd804,  11'd789,  11'd774,  11'd759,
        11'd743,  11'd728,  11'd713,  11'd697,  11'd682,  11'd666,
        11'd651,  11'd635,  11'd619,  11'd604,  11'd588,  11'd572,
        11'd556,  11'd540,  11'd524,  11'd508,  11'd492,  11'd475,
        11'd459,  11'd443,  11'd427,  11'd410,  11'd394,  11'd377,
        11'd361,  11'd344,  11'd328,  11'd311,  11'd294,  11'd278,
        11'd261,  11'd244,  11'd228,  11'd211,  11'd194,  11'd178,
        11'd161,  11'd144,  11'd127,  11'd110,  11'd94,   11'd77
    };

endpackage

### design/stpwm_if.sv
// Valid/ready channel interfaces for the sample input and the compare output.
interface stpwm_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] voltage_sample;

    modport source (output valid, output voltage_sample, input ready);
    modport sink   (input valid, input voltage_sample, output ready);
endinterface

interface stpwm_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] leg_one_compare;
    logic [10:0] leg_two_compare;
    logic        active_half;
    logic [23:0] amplitude_now;

    modport source (output valid, output leg_one_compare, output leg_two_compare,
                    output active_half, output amplitude_now, input ready);
    modport sink   (input valid, input leg_one_compare, input leg_two_compare,
                    input active_half, input amplitude_now, output ready);
endinterface

### design/stpwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stpwm_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 300
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/stpwm_trim.sv
// Amplitude trim and table position/half tracking, one update per accepted word.
module stpwm_trim
    import stpwm_pkg::*;
#(
    parameter int unsigned TABLE_LEN = 300
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [SAMP_W-1:0] i_sample,
    input  t_cfg              i_cfg,
    output t_issue            o_issue,
    output logic [ROM_AW-1:0] o_raddr
);

    localparam int unsigned POS_W = $clog2(TABLE_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TABLE_LEN - 1);

    logic [AMP_W-1:0] r_amp, n_amp;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_half, n_half;

    logic [THR_W-1:0] sum;
    logic [AMP_W:0]   raised;
    logic             in_rom;

    always_comb begin
        sum    = THR_W'(i_sample) + THR_W'(i_cfg.offset);
        raised = {1'b0, r_amp} + (AMP_W + 1)'(i_cfg.step);
        n_amp  = r_amp;
        // low test wins when both thresholds are crossed
        if (sum < i_cfg.low_thr) begin
            n_amp = (raised > (AMP_W + 1)'(AMP_ONE)) ? AMP_ONE : raised[AMP_W-1:0];
        end else if (sum > i_cfg.high_thr) begin
            n_amp = (AMP_W'(i_cfg.step) > r_amp) ? '0 : r_amp - AMP_W'(i_cfg.step);
        end

        // advance before lookup
        if (r_pos == POS_LAST) begin
            n_pos  = '0;
            n_half = ~r_half;
        end else begin
            n_pos  = r_pos + POS_W'(1);
            n_half = r_half;
        end

        // positions beyond the stored table read as zero
        in_rom         = (32'(n_pos) < 32'(ROM_DEPTH));
        o_raddr        = in_rom ? ROM_AW'(n_pos) : '0;
        o_issue.amp    = n_amp;
        o_issue.half   = n_half;
        o_issue.in_rom = in_rom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= AMP_RESET;
            r_pos  <= '0;
            r_half <= 1'b0;
        end else if (i_take) begin
            r_amp  <= n_amp;
            r_pos  <= n_pos;
            r_half <= n_half;
        end
    end

endmodule

### design/stpwm_scale.sv
// Read-data stage, amplitude multiply and output register.
module stpwm_scale
    import stpwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_issue           i_issue,
    input  logic [CMP_W-1:0] i_rdata,
    output logic             o_s1_ready,
    stpwm_out_if.source      o_out
);

    localparam int unsigned PROD_W = CMP_W + AMP_W;

    logic             r_s1_valid;
    t_issue           r_s1;
    logic             r_o_valid;
    logic [CMP_W-1:0] r_leg_one, r_leg_two;
    logic             r_half;
    logic [AMP_W-1:0] r_amp;

    logic              out_en;
    logic [CMP_W-1:0]  word;
    logic [PROD_W-1:0] prod;
    logic [CMP_W-1:0]  cmp;

    always_comb begin
        out_en     = !r_o_valid || o_out.ready;
        o_s1_ready = !r_s1_valid || out_en;
        word       = r_s1.in_rom ? i_rdata : '0;
        prod       = PROD_W'(word) * PROD_W'(r_s1.amp);
        cmp        = prod[FRAC_BITS +: CMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_s1_ready) begin
                r_s1_valid <= i_load;
            end
            if (out_en) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready) begin
            r_s1 <= i_issue;
        end
        if (out_en) begin
            r_leg_one <= r_s1.half ? '0 : cmp;
            r_leg_two <= r_s1.half ? cmp : '0;
            r_half    <= r_s1.half;
            r_amp     <= r_s1.amp;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.leg_one_compare = r_leg_one;
    assign o_out.leg_two_compare = r_leg_two;
    assign o_out.active_half     = r_half;
    assign o_out.amplitude_now   = r_amp;

endmodule

### design/sine_table_pwm_with_amplitude_trim.sv
// Top level: half-sine table PWM generator with amplitude trim.
// Path: an accepted sample word goes to the read stage, then to the output register.
// Throughput: 1 word per cycle while the output is not stalled; amplitude/position update is
//   registered per accepted word, the table RAM read and the 11x24 multiply each take one pipeline stage.
// Reset: synchronous, active low; amplitude returns to 0.8, position and half to 0,
//   registers to defaults. The table RAM is then loaded from the constant table,
//   one entry per cycle for all 300 entries, and input ready stays low during that load.
module sine_table_pwm_with_amplitude_trim
    import stpwm_pkg::*;
#(
    parameter int unsigned TABLE_LEN = 300
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    stpwm_in_if.sink             i_sample,
    stpwm_out_if.source          o_result
);

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step     <= STEP_W'(42);
            r_cfg.low_thr  <= THR_W'(2145);
            r_cfg.high_thr <= THR_W'(2155);
            r_cfg.offset   <= SAMP_W'(1000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP:   r_cfg.step     <= i_cfg_data[STEP_W-1:0];
                CFG_LOW:    r_cfg.low_thr  <= i_cfg_data[THR_W-1:0];
                CFG_HIGH:   r_cfg.high_thr <= i_cfg_data[THR_W-1:0];
                CFG_OFFSET: r_cfg.offset   <= i_cfg_data[SAMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- table load sequencer ----------------
    // Copies the constant half-sine table into the RAM after every reset.
    t_fill_state       r_fill_state, n_fill_state;
    logic [ROM_AW-1:0] r_fill_cnt, n_fill_cnt;
    logic              fill_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_state <= FILL_RUN;
            r_fill_cnt   <= '0;
        end else begin
            r_fill_state <= n_fill_state;
            r_fill_cnt   <= n_fill_cnt;
        end
    end

    always_comb begin
        n_fill_state = r_fill_state;
        n_fill_cnt   = r_fill_cnt;
        fill_we      = 1'b0;
        case (r_fill_state)
            FILL_RUN: begin
                fill_we    = 1'b1;
                n_fill_cnt = r_fill_cnt + ROM_AW'(1);
                if (r_fill_cnt == ROM_AW'(ROM_DEPTH - 1)) begin
                    n_fill_state = FILL_DONE;
                end
            end
            FILL_DONE: begin
            end
            default: begin
                n_fill_state = FILL_RUN;
            end
        endcase
    end

    // ---------------- datapath ----------------
    logic              s1_ready;
    logic              accept;
    t_issue            issue;
    logic [ROM_AW-1:0] raddr;
    logic [CMP_W-1:0]  rdata;

    // Ready depends on the read stage having room and the table load being done, so a word
    // can enter while the previous result is still held at the output.
    assign i_sample.ready = s1_ready && (r_fill_state == FILL_DONE);
    assign accept         = i_sample.valid && i_sample.ready;

    stpwm_trim #(
        .TABLE_LEN (TABLE_LEN)
    ) u_trim (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept),
        .i_sample (i_sample.voltage_sample),
        .i_cfg    (r_cfg),
        .o_issue  (issue),
        .o_raddr  (raddr)
    );

    // The read enable follows the read stage so the RAM data register
    // stays aligned with the word held there.
    stpwm_ram #(
        .WIDTH (CMP_W),
        .DEPTH (ROM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_fill_cnt),
        .i_wdata (SINE_ROM[r_fill_cnt]),
        .i_re    (s1_ready),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    stpwm_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_issue    (issue),
        .i_rdata    (rdata),
        .o_s1_ready (s1_ready),
        .o_out      (o_result)
    );

endmodule

### design/stpwm_checker.sv
// Port-level checker for the sine PWM generator, bound to the top level.
module stpwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [10:0] i_leg_one,
    input logic [10:0] i_leg_two,
    input logic        i_half,
    input logic [23:0] i_amp
);

    // Table load after reset keeps the input closed.
    a_load_blocks_input: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input ready right after reset");

    a_idle_leg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_half && i_leg_one == 11'd0) ||
                         (!i_half && i_leg_two == 11'd0)))
        else $error("inactive leg compare not zero");

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_amp <= 24'd8388608 &&
                         i_leg_one <= 11'd1665 && i_leg_two <= 11'd1665))
        else $error("amplitude or compare out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_leg_one) && $stable(i_leg_two) &&
             $stable(i_half) && $stable(i_amp)))
        else $error("stalled output word changed");

endmodule

bind sine_table_pwm_with_amplitude_trim stpwm_checker u_stpwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_leg_one   (o_result.leg_one_compare),
    .i_leg_two   (o_result.leg_two_compare),
    .i_half      (o_result.active_half),
    .i_amp       (o_result.amplitude_now)
);

### tb/sine_table_pwm_with_amplitude_trim_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sine PWM generator: predicts each compare word and checks the output.
module sine_table_pwm_with_amplitude_trim_checker
    import stpwm_pkg::*;
#(
    parameter int unsigned TABLE_LEN = 300
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    stpwm_in_if                  sample_bus,
    stpwm_out_if                 result_bus,
    output int                   o_errors,
    output int                   o_outstanding
);

    localparam logic [STEP_W-1:0] STEP_DEFAULT   = STEP_W'(42);
    localparam logic [THR_W-1:0]  LOW_DEFAULT    = THR_W'(2145);
    localparam logic [THR_W-1:0]  HIGH_DEFAULT   = THR_W'(2155);
    localparam logic [SAMP_W-1:0] OFFSET_DEFAULT = SAMP_W'(1000);

    typedef struct packed {
        logic [CMP_W-1:0] leg_one;
        logic [CMP_W-1:0] leg_two;
        logic             half;
        logic [AMP_W-1:0] amp;
    } t_compare_word;

    logic [STEP_W-1:0] amp_step;
    logic [THR_W-1:0]  low_thr;
    logic [THR_W-1:0]  high_thr;
    logic [SAMP_W-1:0] meas_offset;

    logic [AMP_W-1:0]  amp;
    int unsigned       table_pos;
    logic              half_sel;

    t_compare_word     pending_compares[$];
    int                err_count;

    // Trim the amplitude with one sample, step the table and build the compare word.
    function t_compare_word next_compare_word(input logic [SAMP_W-1:0] sample);
        logic [13:0]   level;
        logic [24:0]   raised;
        logic [34:0]   product;
        logic [CMP_W-1:0] cmp;
        t_compare_word word;
        level = 14'(sample) + 14'(meas_offset);
        if (level < 14'(low_thr)) begin
            raised = 25'(amp) + 25'(amp_step);
            amp    = (raised > 25'(AMP_ONE)) ? AMP_ONE : raised[AMP_W-1:0];
        end else if (level > 14'(high_thr)) begin
            amp = (AMP_W'(amp_step) > amp) ? '0 : amp - AMP_W'(amp_step);
        end
        if (amp > AMP_ONE) amp = AMP_ONE;

        table_pos++;
        if (table_pos >= TABLE_LEN) begin
            table_pos = 0;
            half_sel  = ~half_sel;
        end

        // positions past the ROM read as zero
        product = (table_pos < ROM_DEPTH) ? 35'(SINE_ROM[table_pos]) * 35'(amp) : '0;
        cmp     = product[FRAC_BITS +: CMP_W];

        word.leg_one = half_sel ? '0 : cmp;
        word.leg_two = half_sel ? cmp : '0;
        word.half    = half_sel;
        word.amp     = amp;
        return word;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_compare_word want;
        t_compare_word got;
        if (!i_rst_n) begin
            amp_step    = STEP_DEFAULT;
            low_thr     = LOW_DEFAULT;
            high_thr    = HIGH_DEFAULT;
            meas_offset = OFFSET_DEFAULT;
            amp         = AMP_RESET;
            table_pos   = 0;
            half_sel    = 1'b0;
            pending_compares.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP:   amp_step    = i_cfg_data[STEP_W-1:0];
                    CFG_LOW:    low_thr     = i_cfg_data[THR_W-1:0];
                    CFG_HIGH:   high_thr    = i_cfg_data[THR_W-1:0];
                    CFG_OFFSET: meas_offset = i_cfg_data[SAMP_W-1:0];
                    default: ;
                endcase
            end
            if (result_bus.valid && result_bus.ready) begin
                got.leg_one = result_bus.leg_one_compare;
                got.leg_two = result_bus.leg_two_compare;
                got.half    = result_bus.active_half;
                got.amp     = result_bus.amplitude_now;
                if (pending_compares.size() == 0) begin
                    $error("compare word with no sample waiting for it");
                    err_count++;
                end else begin
                    want = pending_compares.pop_front();
                    check_field("leg_one_compare", want.leg_one, got.leg_one);
                    check_field("leg_two_compare", want.leg_two, got.leg_two);
                    check_field("active_half", want.half, got.half);
                    check_field("amplitude_now", want.amp, got.amp);
                end
            end
            if (sample_bus.valid && sample_bus.ready)
                pending_compares.push_back(next_compare_word(sample_bus.voltage_sample));
        end
        o_errors      <= err_count;
        o_outstanding <= pending_compares.size();
    end

endmodule

### tb/sine_table_pwm_with_amplitude_trim_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sine PWM generator: clock, reset, stimulus, back-pressure and verdict.
module sine_table_pwm_with_amplitude_trim_tb;
    import stpwm_pkg::*;

    localparam int unsigned TABLE_LEN   = 300;
    // quiet cycles before giving up: covers the table load after reset
    // and the long output hold-off with plenty of margin
    localparam int          QUIET_LIMIT = 4000;
    localparam int          IDLE_PCT    = 23;
    // word counts bounding the stretch where neither side idles
    localparam int          CALM_FROM   = 900;
    localparam int          CALM_TO     = 1100;
    // output word count at which the receiver goes deaf for a while
    localparam int          HOLD_AT     = 500;
    localparam int          HOLD_LEN    = 200;

    typedef enum logic [1:0] {
        SHAPE_ANY,   // full-range noise with the odd extreme value
        SHAPE_BAND   // mostly samples landing near the threshold window
    } t_shape;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    stpwm_in_if  sample_bus ();
    stpwm_out_if result_bus ();

    int errors;
    int outstanding;

    sine_table_pwm_with_amplitude_trim #(
        .TABLE_LEN (TABLE_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_bus),
        .o_result   (result_bus)
    );

    sine_table_pwm_with_amplitude_trim_checker #(
        .TABLE_LEN (TABLE_LEN)
    ) scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .sample_bus    (sample_bus),
        .result_bus    (result_bus),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off so the pipeline
    // fills and the input stalls, and a calm window with ready held high.
    // ------------------------------------------------------------------
    int   words_out = 0;
    int   hold_left = 0;
    logic held      = 1'b0;

    always @(posedge i_clk) begin
        if (result_bus.valid && result_bus.ready) words_out++;
        if (words_out == HOLD_AT && !held) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else if (words_out >= CALM_FROM && words_out < CALM_TO) begin
            result_bus.ready <= 1'b1;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles in which no word moves on either channel.
    // ------------------------------------------------------------------
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("sine_table_pwm_with_amplitude_trim_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int items_sent = 0;

    // Offer one sample word, with random idle cycles ahead of it outside
    // the calm window; returns right after the edge that accepts it.
    task automatic send_sample(input logic [SAMP_W-1:0] sample);
        logic calm;
        calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            sample_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.voltage_sample <= sample;
        do @(posedge i_clk); while (!sample_bus.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted word has come back.
    // The first edge lets the last accepted sample reach the scoreboard.
    task automatic drain();
        sample_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);   // pipeline is two deep; a little margin
    endtask

    // Write all four registers back to back on an idle block.
    task automatic set_config(input logic [STEP_W-1:0] step, input logic [THR_W-1:0] low,
                              input logic [THR_W-1:0] high, input logic [SAMP_W-1:0] offset);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STEP;
        i_cfg_data <= CFG_DAT_W'(step);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LOW;
        i_cfg_data <= CFG_DAT_W'(low);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HIGH;
        i_cfg_data <= CFG_DAT_W'(high);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFFSET;
        i_cfg_data <= CFG_DAT_W'(offset);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Band samples aim the offset sum at the threshold window (+/- a few
    // counts) so the amplitude keeps trimming both ways; one in five is noise.
    function automatic logic [SAMP_W-1:0] pick_sample(input t_shape shape, input int low,
                                                      input int high, input int offset);
        int target;
        if (shape == SHAPE_BAND && $urandom_range(4) != 0) begin
            target = (high > low) ? low + $urandom_range(high - low) : low;
            target = target + $urandom_range(16) - 8 - offset;
            if (target < 0) target = 0;
            if (target > 4095) target = 4095;
            return SAMP_W'(target);
        end
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMP_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic run_phase(input int step, input int low, input int high, input int offset,
                             input int count, input t_shape shape);
        set_config(STEP_W'(step), THR_W'(low), THR_W'(high), SAMP_W'(offset));
        repeat (count) send_sample(pick_sample(shape, low, high, offset));
    endtask

    initial begin
        int low;
        int high;
        i_rst_n                   <= 1'b0;
        i_cfg_we                  <= 1'b0;
        i_cfg_idx                 <= CFG_STEP;
        i_cfg_data                <= '0;
        sample_bus.valid          <= 1'b0;
        sample_bus.voltage_sample <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings (step 42, window 2145..2155, offset 1000).
        send_sample(12'd0);      // far below the window: raise
        send_sample(12'd4095);   // far above: lower
        send_sample(12'd1145);   // sum equals low threshold: hold
        send_sample(12'd1144);   // one under: raise
        send_sample(12'd1155);   // sum equals high threshold: hold
        send_sample(12'd1156);   // one over: lower
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd1150);

        // Every sum sits under the low threshold: amplitude pins at 1.0.
        run_phase(65535, 8191, 8191, 4095, 30, SHAPE_ANY);
        // Window at zero: nearly every sample lowers, amplitude pins at zero.
        run_phase(65535, 0, 0, 0, 140, SHAPE_ANY);
        // Low threshold above the high one: a sum under both raises, not lowers.
        run_phase(1000, 4000, 100, 0, 40, SHAPE_ANY);
        // Zero step: amplitude frozen whatever the sample.
        run_phase(0, 3000, 5000, 2000, 30, SHAPE_BAND);
        // Back to the reset settings, steady trimming around the window.
        run_phase(42, 2145, 2155, 1000, 400, SHAPE_BAND);

        // Random settings, mostly small steps, windows of varied width.
        repeat (6) begin
            low  = $urandom_range(8191);
            high = low + $urandom_range(300);
            if (high > 8191) high = 8191;
            run_phase(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(500),
                      low, high, $urandom_range(4095), 150, SHAPE_BAND);
        end

        drain();
        if (errors == 0 && outstanding == 0)
            $display("sine_table_pwm_with_amplitude_trim_tb: done, clean");
        else
            $display("sine_table_pwm_with_amplitude_trim_tb: done, errors");
        $finish;
    end

endmodule
